/* sv/smx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, codes and constants of the stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

    // Fixed field widths
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CMD_W      = 4;
    localparam int ADDR_IN_W  = 8;
    localparam int ADDR_SPAN  = 2 ** ADDR_IN_W;
    localparam int COUNT_W    = 5;

    // Defaults of the top-level parameters
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_MEM_WORDS   = 256;

    // Shared adder and iteration counts
    localparam int ADD_W     = DATA_WIDTH + 2;
    localparam int QUO_W     = DATA_WIDTH + FRAC_BITS;
    localparam int MUL_STEPS = DATA_WIDTH;
    localparam int DIV_STEPS = DATA_WIDTH + FRAC_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Saturation limits
    localparam logic [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        OP_PUSHI    = 4'd0,
        OP_PUSHMEM  = 4'd1,
        OP_POPSTORE = 4'd2,
        OP_INPUT    = 4'd3,
        OP_PRINT    = 4'd4,
        OP_ADD      = 4'd5,
        OP_SUB      = 4'd6,
        OP_MUL      = 4'd7,
        OP_DIV      = 4'd8,
        OP_SWAP     = 4'd9,
        OP_DROP     = 4'd10,
        OP_DUP      = 4'd11,
        OP_HALT     = 4'd12
    } opcode_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_UNDER   = 3'd1,
        STAT_OVER    = 3'd2,
        STAT_DIVZ    = 3'd3,
        STAT_UNKNOWN = 3'd4,
        STAT_HALTED  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_WRITE,
        ST_SWAP2,
        ST_DONE
    } fsm_state_t;

    // Magnitude of a two's complement value (min maps to 2**(N-1))
    function automatic logic [DATA_WIDTH-1:0] abs_val(input logic [DATA_WIDTH-1:0] v);
        return v[DATA_WIDTH-1] ? (~v + DATA_WIDTH'(1)) : v;
    endfunction

endpackage

/* sv/smx_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_ifs
// Valid/ready channels of the stack machine executor: instructions in,
// results out.
// ----------------------------------------------------------------------------
interface smx_cmd_if import smx_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [CMD_W-1:0]             command;
    logic [ADDR_IN_W-1:0]         mem_address;
    logic signed [DATA_WIDTH-1:0] operand_value;

    modport source (output valid, command, mem_address, operand_value, input ready);
    modport sink   (input valid, command, mem_address, operand_value, output ready);
endinterface

interface smx_res_if import smx_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_value;
    logic                         out_valid;
    logic [2:0]                   status;
    logic [COUNT_W-1:0]           stack_count;

    modport source (output valid, out_value, out_valid, status, stack_count, input ready);
    modport sink   (input valid, out_value, out_valid, status, stack_count, output ready);
endinterface

/* sv/stack_machine_executor_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_executor_core
// Executes one decoded stack-machine instruction per transaction on an
// operand stack and a data memory, Q16.16 saturating arithmetic.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  --------+-----+-------------+------------------------------------------
//  cmd     | in  | valid/ready | command, mem_address, operand_value
//  res     | out | valid/ready | out_value, out_valid, status, stack_count
//
//  After reset a clearing pass zeroes the data memory, word by word,
//  with cmd.ready low. Then one instruction at a time: cmd.ready is high only
//  when the sequencer is idle. Multiply runs 32 shift-add steps and divide
//  48 restoring steps, both on the one shared adder. The result register
//  lets the next instruction enter while a result waits on res.ready; a
//  second result waits in the sequencer until the first is taken.
// ----------------------------------------------------------------------------
module stack_machine_executor_core
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int MEM_WORDS   = DEF_MEM_WORDS
)
(
    input  logic      clk,
    input  logic      rst_n,
    smx_cmd_if.sink   cmd,
    smx_res_if.source res
);

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    typedef logic [AW-1:0] wrap_tab_t [ADDR_SPAN];

    // Address wrap modulo MEM_WORDS, built at elaboration
    function automatic wrap_tab_t build_wrap();
        wrap_tab_t tab;
        for (int i = 0; i < ADDR_SPAN; i++)
        begin
            tab[i] = AW'(i % MEM_WORDS);
        end
        return tab;
    endfunction

    localparam wrap_tab_t ADDR_WRAP = build_wrap();

    // Memories
    logic [DATA_WIDTH-1:0] stk_mem  [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] data_mem [MEM_WORDS];

    // Control registers
    fsm_state_t         state_reg, state_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic               halted_reg, halted_next;
    logic               res_valid_reg, res_valid_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    // Payload registers
    opcode_t               cmd_reg;
    logic [AW-1:0]         addr_reg;
    logic [DATA_WIDTH-1:0] opv_reg;
    logic [DATA_WIDTH-1:0] top_reg, nxt_reg, memrd_reg;
    logic [DATA_WIDTH-1:0] wdata_reg, wdata_next;
    logic [SW-1:0]         widx_reg, widx_next;
    status_t               pst_reg, pst_next;
    logic [DATA_WIDTH-1:0] pov_reg, pov_next;
    logic                  pvalid_reg, pvalid_next;
    logic [DATA_WIDTH-1:0] mag_a_reg, mag_a_next;
    logic [DATA_WIDTH-1:0] mag_b_reg, mag_b_next;
    logic [DATA_WIDTH-1:0] wk_hi_reg, wk_hi_next;
    logic [QUO_W-1:0]      wk_lo_reg, wk_lo_next;
    logic                  neg_reg, neg_next;
    logic [DATA_WIDTH-1:0] out_value_reg;
    logic                  out_valid_reg;
    status_t               status_reg;
    logic [COUNT_W-1:0]    count_reg;

    // Misc combinational signals
    logic                  accept;
    logic                  res_load;
    logic [FW-1:0]         fill_m1, fill_m2;
    logic [SW-1:0]         top_idx, nxt_idx;
    logic                  st_full, st_empty, st_lt2;
    status_t               ex_stat;
    logic                  ex_ok;
    logic [ADD_W-1:0]      add_a, add_b, add_sum;
    logic                  add_sub;
    logic [DATA_WIDTH:0]   r_shift;
    logic [DATA_WIDTH:0]   hi_sum;
    logic                  div_ge;
    logic                  step_last;
    logic [DATA_WIDTH-1:0] fix_mag;
    logic                  fix_big;
    logic [DATA_WIDTH-1:0] addsub_res;
    logic                  stk_we;
    logic [SW-1:0]         stk_widx;
    logic [DATA_WIDTH-1:0] stk_wdata;
    logic                  dm_we;
    logic [AW-1:0]         dm_widx;
    logic [DATA_WIDTH-1:0] dm_wdata;

    assign accept   = cmd.valid && cmd.ready;
    assign res_load = (state_reg == ST_DONE) && (!res_valid_reg || res.ready);

    // Stack pointers and occupancy
    assign fill_m1  = fill_reg - FW'(1);
    assign fill_m2  = fill_reg - FW'(2);
    assign top_idx  = fill_m1[SW-1:0];
    assign nxt_idx  = fill_m2[SW-1:0];
    assign st_full  = (fill_reg >= FW'(STACK_DEPTH));
    assign st_empty = (fill_reg == '0);
    assign st_lt2   = (fill_reg < FW'(2));

    // Instruction check
    always_comb
    begin
        ex_stat = STAT_OK;
        if (halted_reg)
        begin
            ex_stat = STAT_HALTED;
        end
        else
        begin
            unique case (cmd_reg)
                OP_PUSHI, OP_INPUT, OP_PUSHMEM:
                    if (st_full) ex_stat = STAT_OVER;
                OP_POPSTORE, OP_PRINT, OP_DROP:
                    if (st_empty) ex_stat = STAT_UNDER;
                OP_ADD, OP_SUB, OP_MUL, OP_SWAP:
                    if (st_lt2) ex_stat = STAT_UNDER;
                OP_DIV:
                    priority if (st_empty)       ex_stat = STAT_UNDER;
                    else if (top_reg == '0)      ex_stat = STAT_DIVZ;
                    else if (st_lt2)             ex_stat = STAT_UNDER;
                OP_DUP:
                    priority if (st_empty)       ex_stat = STAT_UNDER;
                    else if (st_full)            ex_stat = STAT_OVER;
                OP_HALT:
                    ex_stat = STAT_OK;
                default:
                    ex_stat = STAT_UNKNOWN;
            endcase
        end
    end

    assign ex_ok = (ex_stat == STAT_OK);

    // Shared adder operand select
    assign r_shift = {wk_hi_reg, mag_a_reg[DATA_WIDTH-1]};

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            ST_EXEC:
            begin
                add_a   = {{2{nxt_reg[DATA_WIDTH-1]}}, nxt_reg};
                add_b   = {{2{top_reg[DATA_WIDTH-1]}}, top_reg};
                add_sub = (cmd_reg == OP_SUB);
            end
            ST_MUL:
            begin
                add_a = {2'b00, wk_hi_reg};
                add_b = {2'b00, mag_b_reg};
            end
            ST_DIV:
            begin
                add_a   = {1'b0, r_shift};
                add_b   = {2'b00, mag_b_reg};
                add_sub = 1'b1;
            end
            ST_FIX:
            begin
                add_b   = {2'b00, fix_mag};
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);

    // Step results of the shared adder
    assign hi_sum     = mag_a_reg[0] ? add_sum[DATA_WIDTH:0] : {1'b0, wk_hi_reg};
    assign div_ge     = !add_sum[ADD_W-1];
    assign addsub_res = (add_sum[DATA_WIDTH] != add_sum[DATA_WIDTH-1]) ?
                        (add_sum[DATA_WIDTH] ? VAL_MIN : VAL_MAX) :
                        add_sum[DATA_WIDTH-1:0];
    assign step_last  = (state_reg == ST_MUL) ? (step_reg == STEP_W'(MUL_STEPS - 1)) :
                                                (step_reg == STEP_W'(DIV_STEPS - 1));

    // Scale the product or quotient and flag a magnitude too big to fit
    always_comb
    begin
        if (cmd_reg == OP_MUL)
        begin
            fix_mag = {wk_hi_reg[FRAC_BITS-1:0], wk_lo_reg[DATA_WIDTH-1:FRAC_BITS]};
            fix_big = |wk_hi_reg[DATA_WIDTH-1:FRAC_BITS-1];
        end
        else
        begin
            fix_mag = wk_lo_reg[DATA_WIDTH-1:0];
            fix_big = |wk_lo_reg[QUO_W-1:DATA_WIDTH-1];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == AW'(MEM_WORDS - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (cmd.valid) state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (!ex_ok)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    unique case (cmd_reg)
                        OP_MUL: state_next = ST_MUL;
                        OP_DIV: state_next = ST_DIV;
                        OP_PUSHI, OP_INPUT, OP_PUSHMEM, OP_ADD, OP_SUB, OP_SWAP, OP_DUP:
                            state_next = ST_WRITE;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_MUL, ST_DIV:
                if (step_last) state_next = ST_FIX;
            ST_FIX:
                state_next = ST_WRITE;
            ST_WRITE:
                state_next = (cmd_reg == OP_SWAP) ? ST_SWAP2 : ST_DONE;
            ST_SWAP2:
                state_next = ST_DONE;
            ST_DONE:
                if (res_load) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and control outputs
    always_comb
    begin
        fill_next      = fill_reg;
        halted_next    = halted_reg;
        clr_cnt_next   = clr_cnt_reg;
        step_next      = step_reg;
        res_valid_next = res_valid_reg;
        wdata_next     = wdata_reg;
        widx_next      = widx_reg;
        pst_next       = pst_reg;
        pov_next       = pov_reg;
        pvalid_next    = pvalid_reg;
        mag_a_next     = mag_a_reg;
        mag_b_next     = mag_b_reg;
        wk_hi_next     = wk_hi_reg;
        wk_lo_next     = wk_lo_reg;
        neg_next       = neg_reg;
        stk_we         = 1'b0;
        stk_widx       = widx_reg;
        stk_wdata      = wdata_reg;
        dm_we          = 1'b0;
        dm_widx        = addr_reg;
        dm_wdata       = top_reg;

        // result register drains independently of the sequencer
        if (res_load)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                dm_we        = 1'b1;
                dm_widx      = clr_cnt_reg;
                dm_wdata     = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            ST_EXEC:
            begin
                pst_next    = ex_stat;
                pov_next    = '0;
                pvalid_next = 1'b0;
                step_next   = '0;
                if (ex_ok)
                begin
                    unique case (cmd_reg)
                        OP_PUSHI, OP_INPUT:
                        begin
                            wdata_next = opv_reg;
                            widx_next  = fill_reg[SW-1:0];
                            fill_next  = fill_reg + FW'(1);
                        end
                        OP_PUSHMEM:
                        begin
                            wdata_next = memrd_reg;
                            widx_next  = fill_reg[SW-1:0];
                            fill_next  = fill_reg + FW'(1);
                        end
                        OP_DUP:
                        begin
                            wdata_next = top_reg;
                            widx_next  = fill_reg[SW-1:0];
                            fill_next  = fill_reg + FW'(1);
                        end
                        OP_POPSTORE:
                        begin
                            dm_we     = 1'b1;
                            fill_next = fill_m1;
                        end
                        OP_PRINT, OP_DROP:
                        begin
                            pov_next    = top_reg;
                            pvalid_next = 1'b1;
                            fill_next   = fill_m1;
                        end
                        OP_ADD, OP_SUB:
                        begin
                            wdata_next = addsub_res;
                            widx_next  = nxt_idx;
                            fill_next  = fill_m1;
                        end
                        OP_SWAP:
                        begin
                            wdata_next = top_reg;
                            widx_next  = nxt_idx;
                        end
                        OP_MUL, OP_DIV:
                        begin
                            mag_a_next = abs_val(nxt_reg);
                            mag_b_next = abs_val(top_reg);
                            neg_next   = nxt_reg[DATA_WIDTH-1] ^ top_reg[DATA_WIDTH-1];
                            wk_hi_next = '0;
                            wk_lo_next = '0;
                            widx_next  = nxt_idx;
                            fill_next  = fill_m1;
                        end
                        OP_HALT:
                            halted_next = 1'b1;
                        default:
                            halted_next = halted_reg;
                    endcase
                end
            end
            ST_MUL:
            begin
                // shift-add: accumulate into the high half, shift right
                wk_hi_next = hi_sum[DATA_WIDTH:1];
                wk_lo_next = {{FRAC_BITS{1'b0}}, hi_sum[0], wk_lo_reg[DATA_WIDTH-1:1]};
                mag_a_next = mag_a_reg >> 1;
                step_next  = step_reg + STEP_W'(1);
            end
            ST_DIV:
            begin
                // restoring step: dividend bits enter MSB first, then zeros
                wk_hi_next = div_ge ? add_sum[DATA_WIDTH-1:0] : r_shift[DATA_WIDTH-1:0];
                wk_lo_next = {wk_lo_reg[QUO_W-2:0], div_ge};
                mag_a_next = mag_a_reg << 1;
                step_next  = step_reg + STEP_W'(1);
            end
            ST_FIX:
            begin
                if (fix_big)
                    wdata_next = neg_reg ? VAL_MIN : VAL_MAX;
                else
                    wdata_next = neg_reg ? add_sum[DATA_WIDTH-1:0] : fix_mag;
            end
            ST_WRITE:
            begin
                stk_we = 1'b1;
            end
            ST_SWAP2:
            begin
                stk_we    = 1'b1;
                stk_widx  = widx_reg + SW'(1);
                stk_wdata = nxt_reg;
            end
            default:
            begin
                stk_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            fill_reg      <= '0;
            halted_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            halted_reg    <= halted_next;
            res_valid_reg <= res_valid_next;
            clr_cnt_reg   <= clr_cnt_next;
            step_reg      <= step_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= opcode_t'(cmd.command);
            addr_reg <= ADDR_WRAP[cmd.mem_address];
            opv_reg  <= cmd.operand_value;
        end
        wdata_reg  <= wdata_next;
        widx_reg   <= widx_next;
        pst_reg    <= pst_next;
        pov_reg    <= pov_next;
        pvalid_reg <= pvalid_next;
        mag_a_reg  <= mag_a_next;
        mag_b_reg  <= mag_b_next;
        wk_hi_reg  <= wk_hi_next;
        wk_lo_reg  <= wk_lo_next;
        neg_reg    <= neg_next;
        if (res_load)
        begin
            out_value_reg <= pov_reg;
            out_valid_reg <= pvalid_reg;
            status_reg    <= pst_reg;
            count_reg     <= COUNT_W'(fill_reg);
        end
    end

    // Operand stack: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_widx] <= stk_wdata;
        if (state_reg == ST_IDLE)
        begin
            top_reg <= stk_mem[top_idx];
            nxt_reg <= stk_mem[nxt_idx];
        end
    end

    // Data memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (dm_we)
            data_mem[dm_widx] <= dm_wdata;
        if (state_reg == ST_IDLE)
            memrd_reg <= data_mem[ADDR_WRAP[cmd.mem_address]];
    end

    // Ports
    assign cmd.ready       = (state_reg == ST_IDLE);
    assign res.valid       = res_valid_reg;
    assign res.out_value   = out_value_reg;
    assign res.out_valid   = out_valid_reg;
    assign res.status      = status_reg;
    assign res.stack_count = count_reg;

endmodule

/* sv/smx_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_checker
// Port-level checks of the stack machine executor, bound to the top level.
// ----------------------------------------------------------------------------
module smx_checker
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic [DATA_WIDTH-1:0] out_value,
    input logic                  out_valid,
    input logic [2:0]            status,
    input logic [COUNT_W-1:0]    stack_count
);

    // Stalled result transaction holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_value) && $stable(out_valid)
            && $stable(status) && $stable(stack_count))
        else $error("result changed while stalled");

    // A popped value only comes with an ok status
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> status == STAT_OK)
        else $error("popped value with error status");

    // No popped value means a zero value
    a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_value == '0)
        else $error("nonzero value without pop");

    // Fill never passes the stack depth
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> int'(stack_count) <= STACK_DEPTH)
        else $error("stack count beyond depth");

endmodule

bind stack_machine_executor_core smx_checker #(.STACK_DEPTH(STACK_DEPTH)) u_smx_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .out_value   (res.out_value),
    .out_valid   (res.out_valid),
    .status      (res.status),
    .stack_count (res.stack_count)
);
